// ----- hdl/uds_pkg.sv -----
// Shared constants, types and a helper function for the uudecode stream decoder.
`default_nettype none
package uds_pkg;

  localparam int LINE_LIMIT_DEF = 128;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_E     = 8'h65;
  localparam logic [7:0] CHAR_N     = 8'h6E;
  localparam logic [7:0] CHAR_D     = 8'h64;

  localparam logic [2:0] KIND_DATA  = 3'd0;
  localparam logic [2:0] KIND_END   = 3'd1;
  localparam logic [2:0] KIND_EMPTY = 3'd2;
  localparam logic [2:0] KIND_ZERO  = 3'd3;
  localparam logic [2:0] KIND_EOI   = 3'd4;

  localparam logic [2:0] EWM_FULL   = 3'd3;
  localparam logic [2:0] EWM_MISS   = 3'd4;

  typedef struct packed {
    logic       acr_clear;
    logic       acr_set;
    logic       char_op;
    logic       line_clear;
    logic       line_group;
    logic       emit_data;
    logic       emit_stat;
    logic       last;
    logic [2:0] kind;
  } uds_cmd_t;

  typedef struct packed {
    logic stopped;
    logic eoi;
    logic swallow;
    logic eol;
    logic is_cr;
    logic line_open;
    logic group_fire;
    logic pos_zero;
    logic ewm_end;
    logic count_zero;
    logic owed_nz;
    logic cnt_one;
    logic out_free;
  } uds_sts_t;

  function automatic logic [7:0] end_char(input logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0:    ch = CHAR_E;
      2'd1:    ch = CHAR_N;
      default: ch = CHAR_D;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/uds_dp.sv -----
// Datapath of the uudecode stream decoder: line state, group buffer and result register.
`default_nettype none
module uds_dp #(
  parameter int LINE_LIMIT = uds_pkg::LINE_LIMIT_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_end_of_input,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output logic [7:0]           out_byte,
  output logic [2:0]           out_kind,
  output logic                 out_last_of_run,
  input  wire uds_pkg::uds_cmd_t cmd,
  output uds_pkg::uds_sts_t    sts
);

  localparam int POS_W = $clog2(LINE_LIMIT);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(LINE_LIMIT - 1);

  logic             acr_r, acr_nxt;
  logic             stopped_r, stopped_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [5:0]       owed_r, owed_nxt;
  logic [5:0]       gv_r [3];
  logic [5:0]       gv_nxt [3];
  logic [1:0]       gfill_r, gfill_nxt;
  logic [2:0]       ewm_r, ewm_nxt;
  logic             cended_r, cended_nxt;
  logic             lopen_r, lopen_nxt;
  logic             cz_r, cz_nxt;

  logic [5:0]       ga_r, gb_r, gc_r, gd_r;
  logic [5:0]       ga_nxt, gb_nxt, gc_nxt, gd_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [1:0]       idx_r, idx_nxt;

  logic             ovalid_r, ovalid_nxt;
  logic [7:0]       obyte_r, obyte_nxt;
  logic [2:0]       okind_r, okind_nxt;
  logic             olast_r, olast_nxt;

  logic [7:0]       diff;
  logic [5:0]       val;
  logic             is_eol;
  logic             content;
  logic             dropped;
  logic             ewm_hit;
  logic [1:0]       take;
  logic [7:0]       cur_byte;

  always_comb begin
    diff    = in_byte - uds_pkg::CHAR_SPACE;
    val     = diff[5:0];
    is_eol  = (in_byte == uds_pkg::CHAR_CR) || (in_byte == uds_pkg::CHAR_LF);
    content = (in_byte != uds_pkg::CHAR_NUL) && !cended_r;
    dropped = (pos_r >= POS_MAX);
    ewm_hit = ({{(POS_W-3){1'b0}}, ewm_r} == pos_r) && (pos_r < POS_W'(3)) &&
              (in_byte == uds_pkg::end_char(pos_r[1:0]));
    take    = (owed_r < 6'd3) ? owed_r[1:0] : 2'd3;
    case (idx_r)
      2'd0:    cur_byte = {ga_r, gb_r[5:4]};
      2'd1:    cur_byte = {gb_r[3:0], gc_r[5:2]};
      2'd2:    cur_byte = {gc_r[1:0], gd_r};
      default: cur_byte = 8'h00;
    endcase
  end

  always_comb begin
    sts.stopped    = stopped_r;
    sts.eoi        = in_end_of_input;
    sts.swallow    = acr_r && (in_byte == uds_pkg::CHAR_LF);
    sts.eol        = is_eol;
    sts.is_cr      = (in_byte == uds_pkg::CHAR_CR);
    sts.line_open  = lopen_r;
    sts.group_fire = content && !dropped && (pos_r != '0) && (owed_r != 6'd0) &&
                     (gfill_r == 2'd3);
    sts.pos_zero   = (pos_r == '0);
    sts.ewm_end    = (ewm_r == uds_pkg::EWM_FULL);
    sts.count_zero = cz_r;
    sts.owed_nz    = (owed_r != 6'd0);
    sts.cnt_one    = (cnt_r == 6'd1);
    sts.out_free   = !ovalid_r || out_ready;
  end

  always_comb begin
    acr_nxt     = acr_r;
    stopped_nxt = stopped_r;
    pos_nxt     = pos_r;
    owed_nxt    = owed_r;
    gv_nxt      = gv_r;
    gfill_nxt   = gfill_r;
    ewm_nxt     = ewm_r;
    cended_nxt  = cended_r;
    lopen_nxt   = lopen_r;
    cz_nxt      = cz_r;
    ga_nxt      = ga_r;
    gb_nxt      = gb_r;
    gc_nxt      = gc_r;
    gd_nxt      = gd_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    ovalid_nxt  = ovalid_r && !out_ready;
    obyte_nxt   = obyte_r;
    okind_nxt   = okind_r;
    olast_nxt   = olast_r;

    if (cmd.acr_set) begin
      acr_nxt = 1'b1;
    end else if (cmd.acr_clear) begin
      acr_nxt = 1'b0;
    end

    if (cmd.char_op) begin
      lopen_nxt = 1'b1;
      if (in_byte == uds_pkg::CHAR_NUL) begin
        cended_nxt = 1'b1;
      end else if (!cended_r && !dropped) begin
        ewm_nxt = ewm_hit ? (ewm_r + 3'd1) : uds_pkg::EWM_MISS;
        pos_nxt = pos_r + POS_W'(1);
        if (pos_r == '0) begin
          owed_nxt = val;
          cz_nxt   = (val == 6'd0);
        end else if (owed_r != 6'd0) begin
          if (gfill_r != 2'd3) begin
            gv_nxt[gfill_r] = val;
            gfill_nxt       = gfill_r + 2'd1;
          end else begin
            ga_nxt    = gv_r[0];
            gb_nxt    = gv_r[1];
            gc_nxt    = gv_r[2];
            gd_nxt    = val;
            cnt_nxt   = {4'b0, take};
            idx_nxt   = 2'd0;
            owed_nxt  = owed_r - {4'b0, take};
            gfill_nxt = 2'd0;
          end
        end
      end
    end

    if (cmd.line_group) begin
      ga_nxt  = (gfill_r >= 2'd1) ? gv_r[0] : 6'd0;
      gb_nxt  = (gfill_r >= 2'd2) ? gv_r[1] : 6'd0;
      gc_nxt  = (gfill_r == 2'd3) ? gv_r[2] : 6'd0;
      gd_nxt  = 6'd0;
      cnt_nxt = owed_r;
      idx_nxt = 2'd0;
    end

    if (cmd.line_clear) begin
      pos_nxt    = '0;
      owed_nxt   = 6'd0;
      gv_nxt[0]  = 6'd0;
      gv_nxt[1]  = 6'd0;
      gv_nxt[2]  = 6'd0;
      gfill_nxt  = 2'd0;
      ewm_nxt    = 3'd0;
      cended_nxt = 1'b0;
      lopen_nxt  = 1'b0;
      cz_nxt     = 1'b0;
    end

    if (cmd.emit_data) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = cur_byte;
      okind_nxt  = uds_pkg::KIND_DATA;
      olast_nxt  = cmd.last;
      cnt_nxt    = cnt_r - 6'd1;
      idx_nxt    = (idx_r == 2'd3) ? 2'd3 : (idx_r + 2'd1);
    end

    if (cmd.emit_stat) begin
      ovalid_nxt  = 1'b1;
      obyte_nxt   = 8'h00;
      okind_nxt   = cmd.kind;
      olast_nxt   = 1'b1;
      stopped_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acr_r     <= 1'b0;
      stopped_r <= 1'b0;
      pos_r     <= '0;
      owed_r    <= 6'd0;
      gv_r[0]   <= 6'd0;
      gv_r[1]   <= 6'd0;
      gv_r[2]   <= 6'd0;
      gfill_r   <= 2'd0;
      ewm_r     <= 3'd0;
      cended_r  <= 1'b0;
      lopen_r   <= 1'b0;
      cz_r      <= 1'b0;
      cnt_r     <= 6'd0;
      idx_r     <= 2'd0;
      ovalid_r  <= 1'b0;
    end else begin
      acr_r     <= acr_nxt;
      stopped_r <= stopped_nxt;
      pos_r     <= pos_nxt;
      owed_r    <= owed_nxt;
      gv_r      <= gv_nxt;
      gfill_r   <= gfill_nxt;
      ewm_r     <= ewm_nxt;
      cended_r  <= cended_nxt;
      lopen_r   <= lopen_nxt;
      cz_r      <= cz_nxt;
      cnt_r     <= cnt_nxt;
      idx_r     <= idx_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ga_r    <= ga_nxt;
    gb_r    <= gb_nxt;
    gc_r    <= gc_nxt;
    gd_r    <= gd_nxt;
    obyte_r <= obyte_nxt;
    okind_r <= okind_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_byte        = obyte_r;
  assign out_kind        = okind_r;
  assign out_last_of_run = olast_r;

endmodule
`default_nettype wire

// ----- hdl/uds_ctrl.sv -----
// Controller state machine of the uudecode stream decoder.
`default_nettype none
module uds_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire uds_pkg::uds_sts_t sts,
  output uds_pkg::uds_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINE_END,
    ST_EMIT,
    ST_STATUS
  } state_t;

  state_t     state_r, state_nxt;
  logic       pend_r, pend_nxt;
  logic [2:0] kind_r, kind_nxt;

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && !sts.stopped) begin
          cmd.acr_clear = 1'b1;
          if (sts.eoi) begin
            if (sts.line_open) begin
              pend_nxt  = 1'b1;
              state_nxt = ST_LINE_END;
            end else begin
              kind_nxt  = uds_pkg::KIND_EOI;
              state_nxt = ST_STATUS;
            end
          end else if (sts.swallow) begin
            state_nxt = ST_IDLE;
          end else if (sts.eol) begin
            cmd.acr_set = sts.is_cr;
            pend_nxt    = 1'b0;
            state_nxt   = ST_LINE_END;
          end else begin
            cmd.char_op = 1'b1;
            if (sts.group_fire) begin
              pend_nxt  = 1'b0;
              state_nxt = ST_EMIT;
            end
          end
        end
      end
      ST_LINE_END: begin
        cmd.line_clear = 1'b1;
        if (sts.pos_zero) begin
          kind_nxt  = uds_pkg::KIND_EMPTY;
          state_nxt = ST_STATUS;
        end else if (sts.ewm_end) begin
          kind_nxt  = uds_pkg::KIND_END;
          state_nxt = ST_STATUS;
        end else if (sts.count_zero) begin
          kind_nxt  = uds_pkg::KIND_ZERO;
          state_nxt = ST_STATUS;
        end else if (sts.owed_nz) begin
          cmd.line_group = 1'b1;
          state_nxt      = ST_EMIT;
        end else if (pend_r) begin
          kind_nxt  = uds_pkg::KIND_EOI;
          state_nxt = ST_STATUS;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_data = 1'b1;
          cmd.last      = sts.cnt_one && !pend_r;
          if (sts.cnt_one) begin
            if (pend_r) begin
              kind_nxt  = uds_pkg::KIND_EOI;
              state_nxt = ST_STATUS;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_STATUS: begin
        if (sts.out_free) begin
          cmd.emit_stat = 1'b1;
          cmd.kind      = kind_r;
          cmd.last      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
      kind_r  <= uds_pkg::KIND_DATA;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/uudecode_stream.sv -----
// Top level of the uudecode stream decoder.
// Characters yielding no result are taken while idle and stream at one per cycle; a completed
// group then emits its decoded bytes, taking no input and holding on output stalls. A line end
// is evaluated in the line-end state, then yields any owed bytes and any status result. The
// first result enters the output register from the emit or status state, reached straight from
// acceptance for a completed group or an end of input with no open line, and via the line-end
// state for a line end. Synchronous active-low reset clears all line state and the stop flag.
`default_nettype none
module uudecode_stream #(
  parameter int LINE_LIMIT = uds_pkg::LINE_LIMIT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_input,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [2:0]      out_kind,
  output logic            out_last_of_run
);

  uds_pkg::uds_cmd_t cmd;
  uds_pkg::uds_sts_t sts;

  uds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  uds_dp #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_kind        (out_kind),
    .out_last_of_run (out_last_of_run),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
`default_nettype wire

// ----- hdl/uds_check.sv -----
// Port-level assertion checker for the uudecode stream decoder and its bind statement.
`default_nettype none
module uds_check (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] in_byte,
  input wire logic       in_end_of_input,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic [2:0] out_kind,
  input wire logic       out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_kind) &&
      $stable(out_last_of_run))
    else $error("Result changed while stalled.");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind <= uds_pkg::KIND_EOI)
    else $error("Result kind out of range.");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != uds_pkg::KIND_DATA |-> out_last_of_run && out_byte == 8'h00)
    else $error("Status result is not a final zero-byte result.");

  a_stop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind != uds_pkg::KIND_DATA |=> !out_valid)
    else $error("Result produced after decoding stopped.");

endmodule

bind uudecode_stream uds_check u_uds_check (.*);
`default_nettype wire
